// ===== rtl/pps_pkg.sv =====
// shared constants, types and codes of the priority scheduler
`default_nettype none
package pps_pkg;

    localparam int MAX_TASKS     = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TIME_BITS     = 20;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    // fixed field widths of the channels
    localparam int CMD_W       = 2;
    localparam int IN_TIME_W   = 20;
    localparam int BURST_W     = 16;
    localparam int IN_PRIO_W   = 8;
    localparam int OUT_TIME_W  = 20;
    localparam int OUT_SLOT_W  = 4;
    localparam int OTHERS_W    = 4;
    localparam int OTHERS_MAX  = (1 << OTHERS_W) - 1;
    localparam int WIDE_W      = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [BURST_W-1:0]       t_burst;
    typedef logic [PRIORITY_BITS-1:0] t_prio;
    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [OUT_TIME_W-1:0]    t_out_time;
    typedef logic [WIDE_W-1:0]        t_wide;

    typedef struct packed {
        t_time  arrival;
        t_burst burst;
        t_prio  prio;
        t_burst remaining;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_slot  addr;
        t_entry data;
    } t_mem_wr;

    typedef struct packed {
        logic  en;
        t_slot addr;
    } t_mem_rd;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [IN_TIME_W-1:0] arrival_time;
        t_burst               burst_length;
        logic [IN_PRIO_W-1:0] task_priority;
    } t_task;

    typedef struct packed {
        t_out_time             time_now;
        logic                  cpu_idle;
        logic [OUT_SLOT_W-1:0] running_slot;
        logic [OTHERS_W-1:0]   others_ready;
        logic                  task_finished;
        t_out_time             completion_time;
        t_out_time             turnaround_time;
        t_out_time             waiting_time;
        logic                  all_done;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/pps_in_if.sv =====
// input channel of the scheduler: commands and task loads
`default_nettype none
interface pps_in_if;
    logic                           valid;
    logic                           ready;
    logic [pps_pkg::CMD_W-1:0]      cmd;
    logic [pps_pkg::IN_TIME_W-1:0]  arrival_time;
    logic [pps_pkg::BURST_W-1:0]    burst_length;
    logic [pps_pkg::IN_PRIO_W-1:0]  task_priority;

    modport source (output valid, cmd, arrival_time, burst_length, task_priority,
                    input ready);
    modport sink   (input valid, cmd, arrival_time, burst_length, task_priority,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/pps_out_if.sv =====
// output channel of the scheduler: one record per tick
`default_nettype none
interface pps_out_if;
    logic                            valid;
    logic                            ready;
    logic [pps_pkg::OUT_TIME_W-1:0]  time_now;
    logic                            cpu_idle;
    logic [pps_pkg::OUT_SLOT_W-1:0]  running_slot;
    logic [pps_pkg::OTHERS_W-1:0]    others_ready;
    logic                            task_finished;
    logic [pps_pkg::OUT_TIME_W-1:0]  completion_time;
    logic [pps_pkg::OUT_TIME_W-1:0]  turnaround_time;
    logic [pps_pkg::OUT_TIME_W-1:0]  waiting_time;
    logic                            all_done;

    modport source (output valid, time_now, cpu_idle, running_slot, others_ready,
                    task_finished, completion_time, turnaround_time, waiting_time,
                    all_done, input ready);
    modport sink   (input valid, time_now, cpu_idle, running_slot, others_ready,
                    task_finished, completion_time, turnaround_time, waiting_time,
                    all_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/pps_task_ram.sv =====
// task table memory, one write port and one registered read port
`default_nettype none
module pps_task_ram (
    input  wire logic             i_clk,
    input  wire pps_pkg::t_mem_wr i_wr,
    input  wire pps_pkg::t_mem_rd i_rd,
    output pps_pkg::t_entry       o_rd_data
);

    pps_pkg::t_entry r_mem [pps_pkg::MAX_TASKS];
    pps_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== rtl/pps_ctrl.sv =====
// command sequencer: loads, clears, table scan, pick of best task and write-back
`default_nettype none
module pps_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_task_valid,
    output logic                  o_task_ready,
    input  wire pps_pkg::t_task   i_task,
    output pps_pkg::t_mem_wr      o_mem_wr,
    output pps_pkg::t_mem_rd      o_mem_rd,
    input  wire pps_pkg::t_entry  i_mem_data,
    input  wire logic             i_res_free,
    output logic                  o_res_valid,
    output pps_pkg::t_result      o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam pps_pkg::t_time TIME_MAX = '1;

    // control state
    logic [1:0]       r_state, n_state;
    pps_pkg::t_cnt    r_loaded, n_loaded;
    pps_pkg::t_cnt    r_finished, n_finished;
    pps_pkg::t_time   r_tick, n_tick;
    pps_pkg::t_cnt    r_issue_idx, n_issue_idx;
    logic             r_chk_vld, n_chk_vld;
    logic             r_found, n_found;
    logic             r_skip, n_skip;

    // scan payload
    pps_pkg::t_slot   r_chk_idx, n_chk_idx;
    pps_pkg::t_time   r_comp, n_comp;
    pps_pkg::t_slot   r_best, n_best;
    pps_pkg::t_entry  r_best_ent, n_best_ent;
    pps_pkg::t_time   r_best_tat, n_best_tat;
    pps_pkg::t_cnt    r_ready_cnt, n_ready_cnt;

    logic             accept;
    logic             ent_ready;
    logic             last_chk;
    logic             fin_task;
    pps_pkg::t_cnt    fin_count;
    pps_pkg::t_cnt    others;
    pps_pkg::t_entry  load_ent;
    pps_pkg::t_entry  wb_ent;

    assign o_task_ready = (r_state == ST_IDLE);
    assign accept       = i_task_valid && o_task_ready;

    assign ent_ready = (i_mem_data.arrival <= r_tick) && (i_mem_data.remaining != '0);
    assign last_chk  = r_chk_vld
                       && ((pps_pkg::t_cnt'(r_chk_idx) + pps_pkg::t_cnt'(1)) == r_loaded);

    assign fin_task  = r_found && (r_best_ent.remaining == pps_pkg::t_burst'(1));
    assign fin_count = r_finished + pps_pkg::t_cnt'(fin_task);
    assign others    = r_ready_cnt - pps_pkg::t_cnt'(1);

    always_comb begin
        load_ent.arrival   = pps_pkg::t_time'(i_task.arrival_time);
        load_ent.burst     = i_task.burst_length;
        load_ent.prio      = pps_pkg::t_prio'(i_task.task_priority);
        load_ent.remaining = i_task.burst_length;
        wb_ent             = r_best_ent;
        wb_ent.remaining   = r_best_ent.remaining - pps_pkg::t_burst'(1);
    end

    // memory ports
    always_comb begin
        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = r_loaded[pps_pkg::SLOT_W-1:0];
        o_mem_wr.data = load_ent;
        if (r_state == ST_FIN) begin
            o_mem_wr.en   = i_res_free && r_found;
            o_mem_wr.addr = r_best;
            o_mem_wr.data = wb_ent;
        end else if (accept && (i_task.cmd == pps_pkg::CMD_LOAD)) begin
            o_mem_wr.en = (r_loaded < pps_pkg::t_cnt'(pps_pkg::MAX_TASKS))
                          && (i_task.burst_length != '0);
        end
        o_mem_rd.en   = (r_state == ST_SCAN) && (r_issue_idx < r_loaded);
        o_mem_rd.addr = r_issue_idx[pps_pkg::SLOT_W-1:0];
    end

    // result record built in the finish state
    always_comb begin
        o_res_valid             = (r_state == ST_FIN) && i_res_free;
        o_res.time_now          = pps_pkg::t_out_time'(r_tick);
        o_res.cpu_idle          = !r_found;
        o_res.running_slot      = r_found ? pps_pkg::OUT_SLOT_W'(r_best) : '0;
        o_res.others_ready      = '0;
        o_res.task_finished     = fin_task;
        o_res.completion_time   = '0;
        o_res.turnaround_time   = '0;
        o_res.waiting_time      = '0;
        o_res.all_done          = (fin_count >= r_loaded);
        if (r_found) begin
            o_res.others_ready = (others > pps_pkg::t_cnt'(pps_pkg::OTHERS_MAX))
                                 ? pps_pkg::OTHERS_W'(pps_pkg::OTHERS_MAX)
                                 : pps_pkg::OTHERS_W'(others);
        end
        if (fin_task) begin
            o_res.completion_time = pps_pkg::t_out_time'(r_comp);
            o_res.turnaround_time = pps_pkg::t_out_time'(r_best_tat);
            // floored at zero once time has saturated
            if (pps_pkg::t_wide'(r_best_tat) > pps_pkg::t_wide'(r_best_ent.burst)) begin
                o_res.waiting_time = pps_pkg::t_out_time'(pps_pkg::t_wide'(r_best_tat)
                                     - pps_pkg::t_wide'(r_best_ent.burst));
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_finished  = r_finished;
        n_tick      = r_tick;
        n_issue_idx = r_issue_idx;
        n_chk_vld   = 1'b0;
        n_found     = r_found;
        n_skip      = r_skip;
        n_chk_idx   = o_mem_rd.addr;
        n_comp      = r_comp;
        n_best      = r_best;
        n_best_ent  = r_best_ent;
        n_best_tat  = r_best_tat;
        n_ready_cnt = r_ready_cnt;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_task.cmd)
                        pps_pkg::CMD_LOAD: begin
                            if (o_mem_wr.en) begin
                                n_loaded = r_loaded + pps_pkg::t_cnt'(1);
                            end
                        end
                        pps_pkg::CMD_CLEAR: begin
                            n_loaded   = '0;
                            n_finished = '0;
                            n_tick     = '0;
                        end
                        pps_pkg::CMD_TICK: begin
                            n_issue_idx = '0;
                            n_found     = 1'b0;
                            n_ready_cnt = '0;
                            n_comp      = (r_tick != TIME_MAX)
                                          ? r_tick + pps_pkg::t_time'(1) : r_tick;
                            n_skip      = (r_finished >= r_loaded);
                            n_state     = (r_finished >= r_loaded) ? ST_FIN : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                n_chk_vld = o_mem_rd.en;
                if (o_mem_rd.en) begin
                    n_issue_idx = r_issue_idx + pps_pkg::t_cnt'(1);
                end
                if (r_chk_vld && ent_ready) begin
                    n_ready_cnt = r_ready_cnt + pps_pkg::t_cnt'(1);
                    // strict compare keeps the lowest slot on a tie
                    if (!r_found || (i_mem_data.prio < r_best_ent.prio)) begin
                        n_found    = 1'b1;
                        n_best     = r_chk_idx;
                        n_best_ent = i_mem_data;
                        n_best_tat = r_comp - i_mem_data.arrival;
                    end
                end
                if (last_chk) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_res_free) begin
                    n_finished = fin_count;
                    if (!r_skip) begin
                        n_tick = r_comp;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_loaded    <= '0;
            r_finished  <= '0;
            r_tick      <= '0;
            r_issue_idx <= '0;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_skip      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_finished  <= n_finished;
            r_tick      <= n_tick;
            r_issue_idx <= n_issue_idx;
            r_chk_vld   <= n_chk_vld;
            r_found     <= n_found;
            r_skip      <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx   <= n_chk_idx;
        r_comp      <= n_comp;
        r_best      <= n_best;
        r_best_ent  <= n_best_ent;
        r_best_tat  <= n_best_tat;
        r_ready_cnt <= n_ready_cnt;
    end

    a_fin_le_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished <= r_loaded)
        else $error("finished count above loaded count");

    a_fin_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.task_finished)
        |=> (r_finished == $past(r_finished) + pps_pkg::t_cnt'(1)))
        else $error("completed task not counted");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tick != $past(r_tick))
        |-> ((r_tick == $past(r_tick) + pps_pkg::t_time'(1)) || (r_tick == '0)))
        else $error("time counter jumped");

endmodule
`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
// load, clear and unused commands complete in the cycle they are accepted
// a tick runs the scan state, which reads the task table memory at one read per
// cycle, then the finish state, which fills the result register when it is free
// a tick after all tasks are done skips the scan and goes to the finish state
// the result register lets the next item enter while a result waits
// reset (synchronous, active low) empties the table and zeroes time; no sweep
`default_nettype none
module preemptive_priority_scheduler (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pps_in_if.sink     i_task,
    pps_out_if.source  o_sched
);

    pps_pkg::t_task    task_item;
    pps_pkg::t_mem_wr  mem_wr;
    pps_pkg::t_mem_rd  mem_rd;
    pps_pkg::t_entry   mem_data;
    pps_pkg::t_result  res;
    logic              res_valid;
    logic              res_free;

    // output register
    logic              r_out_valid;
    pps_pkg::t_result  r_out;

    // pack the input channel fields
    always_comb begin
        task_item.cmd           = i_task.cmd;
        task_item.arrival_time  = i_task.arrival_time;
        task_item.burst_length  = i_task.burst_length;
        task_item.task_priority = i_task.task_priority;
    end

    // table of slot records: arrival, burst, priority, remaining work
    pps_task_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd      (mem_rd),
        .o_rd_data (mem_data)
    );

    // sequencer: takes a transfer only when idle, scans, writes back
    pps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (i_task.valid),
        .o_task_ready (i_task.ready),
        .i_task       (task_item),
        .o_mem_wr     (mem_wr),
        .o_mem_rd     (mem_rd),
        .i_mem_data   (mem_data),
        .i_res_free   (res_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // register is free when empty or being drained this cycle
    assign res_free = !r_out_valid || o_sched.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_sched.valid           = r_out_valid;
    assign o_sched.time_now        = r_out.time_now;
    assign o_sched.cpu_idle        = r_out.cpu_idle;
    assign o_sched.running_slot    = r_out.running_slot;
    assign o_sched.others_ready    = r_out.others_ready;
    assign o_sched.task_finished   = r_out.task_finished;
    assign o_sched.completion_time = r_out.completion_time;
    assign o_sched.turnaround_time = r_out.turnaround_time;
    assign o_sched.waiting_time    = r_out.waiting_time;
    assign o_sched.all_done        = r_out.all_done;

endmodule
`default_nettype wire
